>>> rtl/core/kaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_pkg
// Types, constants and fixed-point helpers shared by the angle filter modules.
// ----------------------------------------------------------------------------
package kaf_pkg;

	localparam int DW   = 32;            // state and field width
	localparam int NW   = 31;            // noise register width
	localparam int TW   = 16;            // time step width
	localparam int IW   = 36;            // multiplier operand A width
	localparam int BW   = 33;            // multiplier operand B width, divisor width
	localparam int PW   = IW + BW;       // product width
	localparam int XW   = PW + 1;        // working width for sums
	localparam int RW   = BW + 1;        // divider partial remainder width
	localparam int CIW  = 2;             // register index width
	localparam int CNTW = $clog2(DW);    // quotient bit counter width

	typedef logic signed [DW-1:0] word_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [XW-1:0] wide_t;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_LOAD   = 3'd1;
	localparam logic [2:0] OP_MUL    = 3'd2;
	localparam logic [2:0] OP_WB     = 3'd3;
	localparam logic [2:0] OP_DLOAD  = 3'd4;
	localparam logic [2:0] OP_DSTEP  = 3'd5;
	localparam logic [2:0] OP_DSTORE = 3'd6;
	localparam logic [2:0] OP_OUT    = 3'd7;

	localparam logic [3:0] STP_RATE  = 4'd0;
	localparam logic [3:0] STP_BB    = 4'd1;
	localparam logic [3:0] STP_INNER = 4'd2;
	localparam logic [3:0] STP_QB    = 4'd3;
	localparam logic [3:0] STP_ANG   = 4'd4;
	localparam logic [3:0] STP_BIAS  = 4'd5;
	localparam logic [3:0] STP_AA    = 4'd6;
	localparam logic [3:0] STP_AB    = 4'd7;
	localparam logic [3:0] STP_BA    = 4'd8;
	localparam logic [3:0] STP_LAST  = 4'd9;

	localparam logic [CIW-1:0] REG_QA = 2'd0;
	localparam logic [CIW-1:0] REG_QB = 2'd1;
	localparam logic [CIW-1:0] REG_RM = 2'd2;

	localparam logic [NW-1:0] QA_RST = 31'd16777;
	localparam logic [NW-1:0] QB_RST = 31'd50332;
	localparam logic [NW-1:0] RM_RST = 31'd503316;

	localparam wide_t WMAX = wide_t'(64'sd2147483647);
	localparam wide_t WMIN = wide_t'(-64'sd2147483648);
	localparam prod_t RND16 = prod_t'(64'sd32768);
	localparam prod_t RND30 = prod_t'(64'sd536870912);

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] idx;
		logic       gsel;
	} cmd_t;

	function automatic wide_t sx(input word_t v);
		return {{(XW-DW){v[DW-1]}}, v};
	endfunction

	function automatic wide_t px(input prod_t v);
		return {v[PW-1], v};
	endfunction

	function automatic word_t sat32(input wide_t x);
		word_t r;
		if (x > WMAX)
			r = word_t'(WMAX[DW-1:0]);
		else if (x < WMIN)
			r = word_t'(WMIN[DW-1:0]);
		else
			r = word_t'(x[DW-1:0]);
		return r;
	endfunction

	function automatic prod_t rnd16(input prod_t p);
		prod_t t;
		t = p + RND16;
		return t >>> 16;
	endfunction

	function automatic prod_t rnd30(input prod_t p);
		prod_t t;
		t = p + RND30;
		return t >>> 30;
	endfunction

endpackage

>>> rtl/core/kalman_angle_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_filter_unit
// Two-state angle and gyro bias Kalman filter, one update per input transfer.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall with measured_angle, measured_rate and
// time_step. Output channel: out_valid/out_stall with filtered_angle,
// bias_estimate and zero_variance, one result transfer per input transfer.
// Noise registers are written through cfg_write/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// An update runs ten multiply/write-back pairs on one shared multiplier, two
// radix-2 gain divisions (each with a load and a store state) and one hand-off
// state that raises out_valid. in_stall is high while an update runs, so the
// next item is taken only after the previous update has finished.
// A finished result sits in the output register; the next item is taken
// meanwhile, and its update holds in its final state until that register is
// free. Reset clears the filter state and loads the default noise values.
// ----------------------------------------------------------------------------
module kalman_angle_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [kaf_pkg::DW-1:0] measured_angle,
	input  logic signed [kaf_pkg::DW-1:0] measured_rate,
	input  logic [kaf_pkg::TW-1:0]        time_step,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [kaf_pkg::DW-1:0] filtered_angle,
	output logic signed [kaf_pkg::DW-1:0] bias_estimate,
	output logic                          zero_variance,
	input  logic                          cfg_write,
	input  logic [kaf_pkg::CIW-1:0]       cfg_index,
	input  logic [kaf_pkg::NW-1:0]        cfg_data
);
	import kaf_pkg::*;

	cmd_t cmd;

	kaf_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	kaf_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.measured_angle (measured_angle),
		.measured_rate  (measured_rate),
		.time_step      (time_step),
		.filtered_angle (filtered_angle),
		.bias_estimate  (bias_estimate),
		.zero_variance  (zero_variance)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after input transfer");

	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without an update in progress");

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD |-> !in_stall && in_valid)
		else $error("input load issued outside an input transfer");

endmodule

>>> rtl/core/kaf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_datapath
// Filter state, noise registers, shared multiplier and radix-2 gain divider.
// ----------------------------------------------------------------------------
module kaf_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  kaf_pkg::cmd_t             cmd,
	input  logic                      cfg_write,
	input  logic [kaf_pkg::CIW-1:0]   cfg_index,
	input  logic [kaf_pkg::NW-1:0]    cfg_data,
	input  logic signed [kaf_pkg::DW-1:0] measured_angle,
	input  logic signed [kaf_pkg::DW-1:0] measured_rate,
	input  logic [kaf_pkg::TW-1:0]    time_step,
	output logic signed [kaf_pkg::DW-1:0] filtered_angle,
	output logic signed [kaf_pkg::DW-1:0] bias_estimate,
	output logic                      zero_variance
);
	import kaf_pkg::*;

	logic [NW-1:0] qa_q, qb_q, rm_q;
	word_t ang_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	word_t meas_q, rate_q, y_q, p00_q, p01_q, k0_q, k1_q;
	logic [TW-1:0] dt_q;
	logic signed [IW-1:0] inner_q;
	logic signed [BW-1:0] s_q;
	prod_t prod_q;
	logic zero_q;
	logic [RW-1:0] rem_q;
	logic [BW-1:0] dvs_q;
	logic [DW-1:0] nlo_q, quo_q;
	logic neg_q, ovf_q;
	word_t filt_q, bias_out_q;
	logic zv_q;

	logic signed [IW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	prod_t r16, r30;
	wide_t inner_w, s_w;
	word_t num, kv;
	logic [DW-1:0] mag;
	logic [BW-1:0] dvs_w;
	logic [RW-1:0] sh;
	logic ge, szero, big;

	assign r16   = rnd16(prod_q);
	assign r30   = rnd30(prod_q);
	assign inner_w = px(r16) - sx(ab_q) - sx(ba_q) + {{(XW-NW){1'b0}}, qa_q};
	assign s_w   = sx(aa_q) + {{(XW-NW){1'b0}}, rm_q};
	assign num   = cmd.gsel ? ba_q : aa_q;
	assign mag   = num[DW-1] ? (~num + 1'b1) : num;
	assign dvs_w = s_q[BW-1] ? (~s_q + 1'b1) : s_q;
	assign sh    = {rem_q[BW-1:0], nlo_q[DW-1]};
	assign ge    = sh >= {1'b0, dvs_q};
	assign szero = (s_q == '0);
	assign big   = neg_q ? (quo_q > {1'b1, {(DW-1){1'b0}}}) : quo_q[DW-1];

	always_comb begin
		if (szero)
			kv = '0;
		else if (ovf_q || big)
			kv = neg_q ? word_t'(WMIN[DW-1:0]) : word_t'(WMAX[DW-1:0]);
		else
			kv = neg_q ? word_t'(~quo_q + 1'b1) : word_t'(quo_q);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.idx)
			STP_RATE: begin
				mul_a = {{(IW-TW){1'b0}}, dt_q};
				mul_b = {rate_q[DW-1], rate_q};
			end
			STP_BB: begin
				mul_a = {{(IW-TW){1'b0}}, dt_q};
				mul_b = {bb_q[DW-1], bb_q};
			end
			STP_INNER: begin
				mul_a = inner_q;
				mul_b = {{(BW-TW){1'b0}}, dt_q};
			end
			STP_QB: begin
				mul_a = {{(IW-NW){1'b0}}, qb_q};
				mul_b = {{(BW-TW){1'b0}}, dt_q};
			end
			STP_ANG: begin
				mul_a = {{(IW-DW){k0_q[DW-1]}}, k0_q};
				mul_b = {y_q[DW-1], y_q};
			end
			STP_BIAS: begin
				mul_a = {{(IW-DW){k1_q[DW-1]}}, k1_q};
				mul_b = {y_q[DW-1], y_q};
			end
			STP_AA: begin
				mul_a = {{(IW-DW){k0_q[DW-1]}}, k0_q};
				mul_b = {p00_q[DW-1], p00_q};
			end
			STP_AB: begin
				mul_a = {{(IW-DW){k0_q[DW-1]}}, k0_q};
				mul_b = {p01_q[DW-1], p01_q};
			end
			STP_BA: begin
				mul_a = {{(IW-DW){k1_q[DW-1]}}, k1_q};
				mul_b = {p00_q[DW-1], p00_q};
			end
			default: begin
				mul_a = {{(IW-DW){k1_q[DW-1]}}, k1_q};
				mul_b = {p01_q[DW-1], p01_q};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q   <= QA_RST;
			qb_q   <= QB_RST;
			rm_q   <= RM_RST;
			ang_q  <= '0;
			bias_q <= '0;
			aa_q   <= '0;
			ab_q   <= '0;
			ba_q   <= '0;
			bb_q   <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_QA:  qa_q <= cfg_data;
					REG_QB:  qb_q <= cfg_data;
					REG_RM:  rm_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_WB) begin
				case (cmd.idx)
					STP_RATE:  ang_q <= sat32(sx(ang_q) + px(r16));
					STP_BB: begin
						ab_q <= sat32(sx(ab_q) - px(r16));
						ba_q <= sat32(sx(ba_q) - px(r16));
					end
					STP_INNER: aa_q  <= sat32(sx(aa_q) + px(r16));
					STP_QB:    bb_q  <= sat32(sx(bb_q) + px(r16));
					STP_ANG:   ang_q <= sat32(sx(ang_q) + px(r30));
					STP_BIAS:  bias_q <= sat32(sx(bias_q) + px(r30));
					STP_AA:    aa_q  <= sat32(sx(aa_q) - px(r30));
					STP_AB:    ab_q  <= sat32(sx(ab_q) - px(r30));
					STP_BA:    ba_q  <= sat32(sx(ba_q) - px(r30));
					default:   bb_q  <= sat32(sx(bb_q) - px(r30));
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				meas_q <= measured_angle;
				rate_q <= sat32(sx(measured_rate) - sx(bias_q));
				dt_q   <= time_step;
			end
			OP_MUL: prod_q <= mul_a * mul_b;
			OP_WB: begin
				if (cmd.idx == STP_BB)
					inner_q <= inner_w[IW-1:0];
				if (cmd.idx == STP_QB) begin
					s_q   <= s_w[BW-1:0];
					y_q   <= sat32(sx(meas_q) - sx(ang_q));
					p00_q <= aa_q;
					p01_q <= ab_q;
				end
			end
			OP_DLOAD: begin
				dvs_q <= dvs_w;
				neg_q <= num[DW-1] ^ s_q[BW-1];
				ovf_q <= {{(BW-DW+2){1'b0}}, mag[DW-1:2]} >= dvs_w;
				rem_q <= {{(RW-DW+2){1'b0}}, mag[DW-1:2]};
				nlo_q <= {mag[1:0], {(DW-2){1'b0}}};
				quo_q <= '0;
			end
			OP_DSTEP: begin
				rem_q <= ge ? (sh - {1'b0, dvs_q}) : sh;
				quo_q <= {quo_q[DW-2:0], ge};
				nlo_q <= {nlo_q[DW-2:0], 1'b0};
			end
			OP_DSTORE: begin
				zero_q <= szero;
				if (cmd.gsel)
					k1_q <= kv;
				else
					k0_q <= kv;
			end
			OP_OUT: begin
				filt_q     <= ang_q;
				bias_out_q <= bias_q;
				zv_q       <= zero_q;
			end
			default: ;
		endcase
	end

	assign filtered_angle = filt_q;
	assign bias_estimate  = bias_out_q;
	assign zero_variance  = zv_q;

endmodule

>>> rtl/core/kaf_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_controller
// Sequencer for predict, gain division, correct and result hand-off.
// ----------------------------------------------------------------------------
module kaf_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output kaf_pkg::cmd_t cmd
);
	import kaf_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_WB    = 3'd2;
	localparam logic [2:0] S_DLD   = 3'd3;
	localparam logic [2:0] S_DSTEP = 3'd4;
	localparam logic [2:0] S_DSTO  = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0] state_q;
	logic [3:0] idx_q;
	logic gsel_q;
	logic [CNTW-1:0] cnt_q;
	logic out_valid_q;
	logic out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd.op   = OP_NONE;
		cmd.idx  = idx_q;
		cmd.gsel = gsel_q;
		case (state_q)
			S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_MUL:   cmd.op = OP_MUL;
			S_WB:    cmd.op = OP_WB;
			S_DLD:   cmd.op = OP_DLOAD;
			S_DSTEP: cmd.op = OP_DSTEP;
			S_DSTO:  cmd.op = OP_DSTORE;
			S_FIN:   cmd.op = out_free ? OP_OUT : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= STP_RATE;
			gsel_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= STP_RATE;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_WB;
				S_WB: begin
					if (idx_q == STP_QB) begin
						gsel_q  <= 1'b0;
						state_q <= S_DLD;
					end else if (idx_q == STP_LAST) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= S_MUL;
					end
				end
				S_DLD: begin
					cnt_q   <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(DW - 1))
						state_q <= S_DSTO;
				end
				S_DSTO: begin
					if (gsel_q) begin
						idx_q   <= STP_ANG;
						state_q <= S_MUL;
					end else begin
						gsel_q  <= 1'b1;
						state_q <= S_DLD;
					end
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
